@@ hdl/q2e_pkg.sv @@
// ----------------------------------------------------------------------------
// q2e_pkg: shared types and constants
// Transaction payload types, default sizes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package q2e_pkg;

    localparam int COMPONENT_WIDTH_DEF = 16;
    localparam int CORDIC_STAGES_DEF   = 16;
    localparam int QUAT_W  = COMPONENT_WIDTH_DEF;
    localparam int ANGLE_W = 16;
    localparam int TIME_W  = 48;
    localparam int GUARD   = 16;
    localparam int ACC_W   = 34;

    typedef struct packed {
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
        logic signed [QUAT_W-1:0] quat_w;
        logic        [TIME_W-1:0] sample_time;
    } t_quat_in;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll_angle;
        logic signed [ANGLE_W-1:0] pitch_angle;
        logic signed [ANGLE_W-1:0] yaw_angle;
        logic        [TIME_W-1:0]  result_time;
    } t_euler_out;

    // atan(2^-i) in units where 2^31 = pi
    function automatic logic [31:0] atan_val(input int i);
        logic [31:0] r;
        case (i)
            0:  r = 32'h20000000;  1: r = 32'h12E4051E;  2: r = 32'h09FB385B;
            3:  r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
            6:  r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
            9:  r = 32'h00145F2F; 10: r = 32'h000A2F98; 11: r = 32'h000517CC;
            12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2FA;
            15: r = 32'h0000517D; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
            18: r = 32'h00000A30; 19: r = 32'h00000518; 20: r = 32'h0000028C;
            21: r = 32'h00000146; 22: r = 32'h000000A3; 23: r = 32'h00000051;
            24: r = 32'h00000029; 25: r = 32'h00000014; 26: r = 32'h0000000A;
            27: r = 32'h00000005; 28: r = 32'h00000003; 29: r = 32'h00000001;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/quaternion_to_euler_angles.sv @@
// Throughput: one quaternion per cycle; busy stays low, start may be high every cycle.
// The depth is set by the bit-per-stage square root and the CORDIC stage count.
// Synchronous active-low reset clears all valid bits; no results are in flight after it.
// Each result appears for one cycle with done high; the receiver cannot stall.
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles: quaternion to roll, pitch and yaw
// Fully pipelined products, integer square root and three CORDIC atan2 units.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles #(
    parameter int CORDIC_STAGES   = q2e_pkg::CORDIC_STAGES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  q2e_pkg::t_quat_in    i_quat,
    output logic                 o_busy,
    output logic                 o_done,
    output q2e_pkg::t_euler_out  o_euler
);
    import q2e_pkg::*;

    // component width follows the payload type
    localparam int COMPONENT_WIDTH = QUAT_W;
    localparam int CW   = COMPONENT_WIDTH;
    localparam int FRAC = CW - 2;
    localparam int TW   = CW + 4;
    localparam int SW   = CW + 1;
    localparam int SIDE_W = 4*TW + SW;
    localparam int LAT  = 3 + (FRAC + 1) + CORDIC_STAGES + 2;

    logic t_valid;
    logic signed [TW-1:0] t_ry, t_rx, t_yy, t_yx;
    logic signed [SW-1:0] t_s;
    logic [2*FRAC:0] t_v;
    logic q_valid;
    logic [FRAC:0] q_root;
    logic [SIDE_W-1:0] q_side;
    logic signed [TW-1:0] q_ry, q_rx, q_yy, q_yx;
    logic signed [SW-1:0] q_s;
    logic roll_vl, pitch_vl, yaw_vl;
    logic [15:0] roll_a, pitch_a, yaw_a;
    logic [TIME_W-1:0] r_time [0:LAT-1];

    q2e_terms #(.CW(CW)) u_terms (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_start),
        .i_x(CW'(i_quat.quat_x)), .i_y(CW'(i_quat.quat_y)),
        .i_z(CW'(i_quat.quat_z)), .i_w(CW'(i_quat.quat_w)),
        .o_valid(t_valid), .o_roll_y(t_ry), .o_roll_x(t_rx), .o_s(t_s),
        .o_yaw_y(t_yy), .o_yaw_x(t_yx), .o_v(t_v)
    );

    q2e_isqrt #(.FRAC(FRAC), .SIDE_W(SIDE_W)) u_isqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(t_valid), .i_v(t_v),
        .i_side({t_ry, t_rx, t_s, t_yy, t_yx}),
        .o_valid(q_valid), .o_root(q_root), .o_side(q_side)
    );

    assign {q_ry, q_rx, q_s, q_yy, q_yx} = q_side;

    q2e_cordic #(.TW(TW), .NS(CORDIC_STAGES)) u_roll (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid),
        .i_y(q_ry), .i_x(q_rx), .o_valid(roll_vl), .o_angle(roll_a)
    );

    q2e_cordic #(.TW(TW), .NS(CORDIC_STAGES)) u_pitch (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid),
        .i_y(TW'(q_s)), .i_x(TW'({1'b0, q_root})),
        .o_valid(pitch_vl), .o_angle(pitch_a)
    );

    q2e_cordic #(.TW(TW), .NS(CORDIC_STAGES)) u_yaw (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid),
        .i_y(q_yy), .i_x(q_yx), .o_valid(yaw_vl), .o_angle(yaw_a)
    );

    // carry the timestamp alongside the datapath
    always_ff @(posedge i_clk) begin
        r_time[0] <= i_quat.sample_time;
        for (int k = 1; k < LAT; k++) begin
            r_time[k] <= r_time[k-1];
        end
    end

    assign o_busy = 1'b0;
    assign o_done = pitch_vl & roll_vl & yaw_vl;
    assign o_euler.roll_angle  = roll_a;
    assign o_euler.pitch_angle = pitch_a;
    assign o_euler.yaw_angle   = yaw_a;
    assign o_euler.result_time = r_time[LAT-1];

endmodule

@@ hdl/q2e_terms.sv @@
// ----------------------------------------------------------------------------
// q2e_terms: quaternion products and atan2 operands
// Three stages: products, roll/pitch/yaw terms, and 1 - s*s for the sqrt.
// ----------------------------------------------------------------------------
module q2e_terms #(
    parameter int CW = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic signed [CW-1:0]  i_x,
    input  logic signed [CW-1:0]  i_y,
    input  logic signed [CW-1:0]  i_z,
    input  logic signed [CW-1:0]  i_w,
    output logic                  o_valid,
    output logic signed [CW+3:0]  o_roll_y,
    output logic signed [CW+3:0]  o_roll_x,
    output logic signed [CW:0]    o_s,
    output logic signed [CW+3:0]  o_yaw_y,
    output logic signed [CW+3:0]  o_yaw_x,
    output logic [2*CW-4:0]       o_v
);
    import q2e_pkg::*;

    localparam int FRAC = CW - 2;
    localparam int PW   = CW + 2;
    localparam int TW   = CW + 4;
    localparam int SW   = CW + 1;
    localparam int VW   = 2*FRAC + 1;
    localparam logic signed [TW-1:0] ONE = TW'(1) << FRAC;

    function automatic logic signed [PW-1:0] mulq(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        logic signed [2*CW-1:0] p;
        p = a * b;
        return PW'(p >>> FRAC);
    endfunction

    logic signed [PW-1:0] r_xx, r_yy, r_zz, r_wx, r_wy, r_wz, r_xy, r_yz, r_zx;
    logic                 r_v1, r_v2, r_v3;
    logic signed [TW-1:0] r_ry2, r_rx2, r_yy2, r_yx2, r_ry3, r_rx3, r_yy3, r_yx3;
    logic signed [SW-1:0] r_s2, r_s3;
    logic [VW-1:0]        r_v;
    logic signed [TW-1:0] n_s;
    logic signed [2*SW-1:0] w_ss;

    always_comb begin
        n_s = (TW'(r_wy) - TW'(r_zx)) <<< 1;
        if (n_s > ONE) n_s = ONE;
        if (n_s < -ONE) n_s = -ONE;
        w_ss = r_s2 * r_s2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_xx <= mulq(i_x, i_x);
        r_yy <= mulq(i_y, i_y);
        r_zz <= mulq(i_z, i_z);
        r_wx <= mulq(i_w, i_x);
        r_wy <= mulq(i_w, i_y);
        r_wz <= mulq(i_w, i_z);
        r_xy <= mulq(i_x, i_y);
        r_yz <= mulq(i_y, i_z);
        r_zx <= mulq(i_z, i_x);
        r_ry2 <= (TW'(r_wx) + TW'(r_yz)) <<< 1;
        r_rx2 <= ONE - ((TW'(r_xx) + TW'(r_yy)) <<< 1);
        r_yy2 <= (TW'(r_wz) + TW'(r_xy)) <<< 1;
        r_yx2 <= ONE - ((TW'(r_yy) + TW'(r_zz)) <<< 1);
        r_s2  <= SW'(n_s);
        r_ry3 <= r_ry2;
        r_rx3 <= r_rx2;
        r_yy3 <= r_yy2;
        r_yx3 <= r_yx2;
        r_s3  <= r_s2;
        r_v   <= VW'(((2*SW)'(1) << (2*FRAC)) - w_ss);
    end

    assign o_valid  = r_v3;
    assign o_roll_y = r_ry3;
    assign o_roll_x = r_rx3;
    assign o_s      = r_s3;
    assign o_yaw_y  = r_yy3;
    assign o_yaw_x  = r_yx3;
    assign o_v      = r_v;

endmodule

@@ hdl/q2e_isqrt.sv @@
// ----------------------------------------------------------------------------
// q2e_isqrt: pipelined floor integer square root
// One result bit per stage, side payload carried alongside.
// ----------------------------------------------------------------------------
module q2e_isqrt #(
    parameter int FRAC   = 14,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [2*FRAC:0]   i_v,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [FRAC:0]     o_root,
    output logic [SIDE_W-1:0] o_side
);
    import q2e_pkg::*;

    localparam int N  = FRAC + 1;
    localparam int VW = 2*FRAC + 1;
    localparam int RW = VW + 1;

    logic [VW-1:0]     w_v  [0:N];
    logic [RW-1:0]     w_r  [0:N];
    logic [SIDE_W-1:0] w_sd [0:N];
    logic              w_vl [0:N];

    assign w_v[0]  = i_v;
    assign w_r[0]  = '0;
    assign w_sd[0] = i_side;
    assign w_vl[0] = i_valid;

    for (genvar k = 0; k < N; k++) begin : g_step
        localparam logic [RW-1:0] BIT = RW'(1) << (2*(FRAC-k));
        logic [RW-1:0] w_t;
        logic [VW-1:0] r_v, n_v;
        logic [RW-1:0] r_r, n_r;
        logic [SIDE_W-1:0] r_sd;
        logic r_vl;
        always_comb begin
            w_t = w_r[k] + BIT;
            if ({1'b0, w_v[k]} >= w_t) begin
                n_v = VW'({1'b0, w_v[k]} - w_t);
                n_r = (w_r[k] >> 1) + BIT;
            end else begin
                n_v = w_v[k];
                n_r = w_r[k] >> 1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vl <= 1'b0;
            end else begin
                r_vl <= w_vl[k];
            end
            r_v  <= n_v;
            r_r  <= n_r;
            r_sd <= w_sd[k];
        end
        assign w_v[k+1]  = r_v;
        assign w_r[k+1]  = r_r;
        assign w_sd[k+1] = r_sd;
        assign w_vl[k+1] = r_vl;
    end

    assign o_valid = w_vl[N];
    assign o_root  = w_r[N][FRAC:0];
    assign o_side  = w_sd[N];

endmodule

@@ hdl/q2e_cordic.sv @@
// ----------------------------------------------------------------------------
// q2e_cordic: pipelined vectoring CORDIC atan2
// Quadrant fold, one micro-rotation per stage, rounding to a binary angle.
// ----------------------------------------------------------------------------
module q2e_cordic #(
    parameter int TW = 20,
    parameter int NS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic signed [TW-1:0] i_y,
    input  logic signed [TW-1:0] i_x,
    output logic               o_valid,
    output logic [15:0]        o_angle
);
    import q2e_pkg::*;

    localparam int XW = TW + GUARD + 3;
    localparam logic signed [ACC_W-1:0] PI = ACC_W'(1) << 31;

    logic signed [XW-1:0]    w_x  [0:NS];
    logic signed [XW-1:0]    w_y  [0:NS];
    logic signed [ACC_W-1:0] w_a  [0:NS];
    logic                    w_sp [0:NS];
    logic [15:0]             w_sa [0:NS];
    logic                    w_vl [0:NS];

    logic signed [XW-1:0] r_x0, r_y0, n_x0, n_y0;
    logic signed [ACC_W-1:0] r_a0, n_a0;
    logic r_sp0, r_vl0;
    logic [15:0] r_sa0, n_sa0;

    always_comb begin
        n_x0 = XW'(i_x) <<< GUARD;
        n_y0 = XW'(i_y) <<< GUARD;
        n_a0 = '0;
        if (i_x < 0) begin
            n_a0 = (i_y >= 0) ? PI : -PI;
            n_x0 = -n_x0;
            n_y0 = -n_y0;
        end
        if (i_y == 0) n_sa0 = 16'h0000;
        else if (i_y > 0) n_sa0 = 16'h4000;
        else n_sa0 = 16'hC000;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vl0 <= 1'b0;
        end else begin
            r_vl0 <= i_valid;
        end
        r_x0  <= n_x0;
        r_y0  <= n_y0;
        r_a0  <= n_a0;
        r_sp0 <= (i_x == 0);
        r_sa0 <= n_sa0;
    end

    assign w_x[0]  = r_x0;
    assign w_y[0]  = r_y0;
    assign w_a[0]  = r_a0;
    assign w_sp[0] = r_sp0;
    assign w_sa[0] = r_sa0;
    assign w_vl[0] = r_vl0;

    for (genvar i = 0; i < NS; i++) begin : g_rot
        localparam logic signed [ACC_W-1:0] ATN = ACC_W'(atan_val(i));
        logic signed [XW-1:0] r_x, r_y;
        logic signed [ACC_W-1:0] r_a;
        logic r_sp, r_vl;
        logic [15:0] r_sa;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vl <= 1'b0;
            end else begin
                r_vl <= w_vl[i];
            end
            if (w_y[i] >= 0) begin
                r_x <= w_x[i] + (w_y[i] >>> i);
                r_y <= w_y[i] - (w_x[i] >>> i);
                r_a <= w_a[i] + ATN;
            end else begin
                r_x <= w_x[i] - (w_y[i] >>> i);
                r_y <= w_y[i] + (w_x[i] >>> i);
                r_a <= w_a[i] - ATN;
            end
            r_sp <= w_sp[i];
            r_sa <= w_sa[i];
        end
        assign w_x[i+1]  = r_x;
        assign w_y[i+1]  = r_y;
        assign w_a[i+1]  = r_a;
        assign w_sp[i+1] = r_sp;
        assign w_sa[i+1] = r_sa;
        assign w_vl[i+1] = r_vl;
    end

    logic signed [ACC_W-1:0] w_rnd;
    logic r_vl;
    logic [15:0] r_ang;

    assign w_rnd = (w_a[NS] + ACC_W'(32768)) >>> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vl <= 1'b0;
        end else begin
            r_vl <= w_vl[NS];
        end
        r_ang <= w_sp[NS] ? w_sa[NS] : w_rnd[15:0];
    end

    assign o_valid = r_vl;
    assign o_angle = r_ang;

endmodule

@@ hdl/q2e_checker.sv @@
// ----------------------------------------------------------------------------
// q2e_checker: port-level checks for the quaternion converter
// Busy never raised, fixed latency, timestamp pass-through and pitch range.
// ----------------------------------------------------------------------------
module q2e_checker #(
    parameter int LAT = 36
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_start,
    input q2e_pkg::t_quat_in   i_quat,
    input logic                o_busy,
    input logic                o_done,
    input q2e_pkg::t_euler_out o_euler
);
    import q2e_pkg::*;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !o_busy)
        else $error("busy raised");

    a_done_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, LAT))
        else $error("result without transaction");

    a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_euler.result_time == $past(i_quat.sample_time, LAT))
        else $error("timestamp mismatch");

    a_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($signed(o_euler.pitch_angle) <= 16384 &&
                    $signed(o_euler.pitch_angle) >= -16384))
        else $error("pitch out of range");

endmodule

bind quaternion_to_euler_angles q2e_checker #(
    .LAT(COMPONENT_WIDTH + CORDIC_STAGES + 4)
) u_q2e_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_quat(i_quat),
    .o_busy(o_busy), .o_done(o_done), .o_euler(o_euler)
);
